/* rtl/core/csd_pkg.sv */
// ----------------------------------------------------------------------------
// Command stream deframer package
// Shared widths, codes, tables and types of the command stream deframer.
// ----------------------------------------------------------------------------
package csd_pkg;

	// Default width of the delivered byte count.
	localparam int COUNT_WIDTH_DEF = 24;

	// Fixed field widths.
	localparam int CODE_W  = 8;
	localparam int IMAGE_W = 24;

	// Header, sync word and flash skip lengths.
	localparam int HDR_LEN    = 3;
	localparam int SYNC_LEN   = 4;
	localparam int FLASH_SKIP = 4;
	localparam int MATCH_W    = $clog2(HDR_LEN + 1);
	localparam int BEAT_W     = $clog2(SYNC_LEN);
	localparam int SKIP_W     = $clog2(FLASH_SKIP + 1);

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] HEADER_BYTES [HDR_LEN] = '{8'h7E, 8'hAA, 8'h99};
	localparam logic [7:0] SYNC_BYTES [SYNC_LEN]  = '{8'h7E, 8'hAA, 8'h99, 8'h7E};

	// Register reset values.
	localparam logic [CODE_W-1:0]  CONFIGURE_CODE_RST = 8'h7E;
	localparam logic [CODE_W-1:0]  FLASH_CODE_RST     = 8'h01;
	localparam logic [CODE_W-1:0]  COUNTER_CODE_RST   = 8'h02;
	localparam logic [IMAGE_W-1:0] IMAGE_BYTES_RST    = 24'd135100;

	// Targets of a stream.
	typedef enum logic [1:0] {
		TGT_NONE  = 2'd0,
		TGT_CONF  = 2'd1,
		TGT_FLASH = 2'd2,
		TGT_COUNT = 2'd3
	} target_t;

	// Front phase.
	typedef enum logic [1:0] {
		PH_SCAN = 2'd0,
		PH_CMD  = 2'd1,
		PH_RUN  = 2'd2
	} phase_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_CONFIGURE_CODE = 2'd0,
		REG_FLASH_CODE     = 2'd1,
		REG_COUNTER_CODE   = 2'd2,
		REG_IMAGE_BYTES    = 2'd3
	} cfg_reg_t;

	// Current register settings.
	typedef struct packed {
		logic [CODE_W-1:0]  configure_code;
		logic [CODE_W-1:0]  flash_code;
		logic [CODE_W-1:0]  counter_code;
		logic [IMAGE_W-1:0] image_bytes;
	} cfg_regs_t;

	// One classified item as the front hands it to the back.
	// A sync entry expands into the four-byte sync burst.
	typedef struct packed {
		target_t    target;
		logic [7:0] data;
		logic       done;
		logic       sync;
	} item_t;

endpackage

/* rtl/core/csd_if.sv */
// ----------------------------------------------------------------------------
// Command stream deframer channels
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface csd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_end;

	modport source (output valid, output data_byte, output stream_end, input ready);
	modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

interface csd_out_if #(
	parameter int COUNT_WIDTH = csd_pkg::COUNT_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	csd_pkg::target_t       target;
	logic [7:0]             out_byte;
	logic [COUNT_WIDTH-1:0] byte_count;
	logic                   image_done;
	logic                   last;

	modport source (output valid, output target, output out_byte, output byte_count,
		output image_done, output last, input ready);
	modport sink (input valid, input target, input out_byte, input byte_count,
		input image_done, input last, output ready);
endinterface

interface csd_cfg_if;
	logic                            valid;
	logic                            ready;
	csd_pkg::cfg_reg_t               index;
	logic [csd_pkg::IMAGE_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/command_stream_deframer.sv */
// ----------------------------------------------------------------------------
// Command stream deframer
// Finds the header in a byte stream, decodes the command byte and routes the
// payload bytes to the selected target with a running count.
// ----------------------------------------------------------------------------
//
// Channel   Role    Item
// stream    sink    data_byte, stream_end
// result    source  target, out_byte, byte_count, image_done, last
// cfg       sink    index, data (register write, always ready)
//
// One byte is accepted per cycle while the queue has room. An accepted byte
// is first written to the queue, and the back then loads its result from the
// queue into the output register, from which the result can be taken.
// A configure command yields the four sync results from the back;
// the four-entry queue between front and back absorbs that burst.
// The front stalls only when the queue is full, the back only on result.ready.
// Reset clears the scan state, the queue and the output valid flag, and loads
// the register defaults.
//
module command_stream_deframer #(
	parameter int COUNT_WIDTH = csd_pkg::COUNT_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	csd_in_if.sink    stream,
	csd_out_if.source result,
	csd_cfg_if.sink   cfg
);
	import csd_pkg::*;

	cfg_regs_t              regs_q;
	logic                   q_full;
	logic                   q_empty;
	logic                   push;
	logic                   pop;
	item_t                  push_item;
	item_t                  head_item;
	logic [COUNT_WIDTH-1:0] push_count;
	logic [COUNT_WIDTH-1:0] head_count;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.configure_code <= CONFIGURE_CODE_RST;
			regs_q.flash_code     <= FLASH_CODE_RST;
			regs_q.counter_code   <= COUNTER_CODE_RST;
			regs_q.image_bytes    <= IMAGE_BYTES_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_CONFIGURE_CODE: regs_q.configure_code <= cfg.data[CODE_W-1:0];
				REG_FLASH_CODE:     regs_q.flash_code     <= cfg.data[CODE_W-1:0];
				REG_COUNTER_CODE:   regs_q.counter_code   <= cfg.data[CODE_W-1:0];
				REG_IMAGE_BYTES:    regs_q.image_bytes    <= cfg.data;
				default: ;
			endcase
		end
	end

	csd_front #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.regs       (regs_q),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item),
		.push_count (push_count)
	);

	csd_queue #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.DEPTH       (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_count (push_count),
		.full       (q_full),
		.pop        (pop),
		.empty      (q_empty),
		.head_item  (head_item),
		.head_count (head_count)
	);

	csd_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head_item  (head_item),
		.head_count (head_count),
		.pop        (pop),
		.result     (result)
	);

	// Only the sync burst spreads one byte over several results.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.last |-> result.target == TGT_CONF)
		else $error("non-last result outside a configure sync burst");

	// A sync burst continues in the cycle after each of its beats is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.last
		|=> result.valid && result.target == TGT_CONF)
		else $error("sync burst broken up");

	// Scanned bytes carry no count and never complete a stream.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.target == TGT_NONE
		|-> result.byte_count == '0 && !result.image_done && result.last)
		else $error("scanned byte with count or completion");

	// Completion is only ever flagged on the last result of a byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.image_done |-> result.last)
		else $error("completion before the last result of a byte");

endmodule

/* rtl/core/csd_front.sv */
// ----------------------------------------------------------------------------
// Command stream deframer front
// Accepts bytes, scans for the header, decodes the command and tracks the
// stream count, and queues an item per byte but the dropped flash preamble.
// ----------------------------------------------------------------------------
module csd_front #(
	parameter int COUNT_WIDTH = csd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	csd_in_if.sink                 stream,
	input  csd_pkg::cfg_regs_t     regs,
	input  logic                   q_full,
	output logic                   push,
	output csd_pkg::item_t         push_item,
	output logic [COUNT_WIDTH-1:0] push_count
);
	import csd_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > IMAGE_W) ? COUNT_WIDTH : IMAGE_W;

	phase_t               phase_q, phase_d;
	logic [MATCH_W-1:0]   match_q, match_d;
	target_t              target_q, target_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic [SKIP_W-1:0]    skip_q, skip_d;

	logic                 accept;
	logic [MATCH_W-1:0]   match_pos;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic [CMP_W-1:0]     image_x;
	logic                 image_hit;
	logic                 sync_done;
	target_t              cmd_target;

	assign stream.ready = !q_full;
	assign accept       = stream.valid && stream.ready;

	// Saturating count and the image size compare.
	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
	assign image_x   = CMP_W'(regs.image_bytes);
	assign image_hit = CMP_W'(count_inc) >= image_x;
	assign sync_done = stream.stream_end || (image_x <= CMP_W'(SYNC_LEN));

	// Command decode; the counter code wins over flash, flash over configure.
	always_comb begin
		priority if (stream.data_byte == regs.counter_code) begin
			cmd_target = TGT_COUNT;
		end else if (stream.data_byte == regs.flash_code) begin
			cmd_target = TGT_FLASH;
		end else if (stream.data_byte == regs.configure_code) begin
			cmd_target = TGT_CONF;
		end else begin
			cmd_target = TGT_NONE;
		end
	end

	assign match_pos = (match_q > MATCH_W'(HDR_LEN - 1)) ? '0 : match_q;

	// Next state and the item for the queue.
	always_comb begin
		phase_d    = phase_q;
		match_d    = match_q;
		target_d   = target_q;
		count_d    = count_q;
		skip_d     = skip_q;
		push       = 1'b0;
		push_item  = '{target: TGT_NONE, data: stream.data_byte, done: 1'b0, sync: 1'b0};
		push_count = '0;

		if (accept) begin
			unique case (phase_q)
				PH_CMD: begin
					push = 1'b1;
					unique case (cmd_target)
						TGT_NONE: begin
							phase_d = PH_SCAN;
						end
						TGT_CONF: begin
							push_item.target = TGT_CONF;
							push_item.sync   = 1'b1;
							push_item.done   = sync_done;
							phase_d          = sync_done ? PH_SCAN : PH_RUN;
							target_d         = sync_done ? TGT_NONE : TGT_CONF;
							count_d          = sync_done ? '0 : COUNT_WIDTH'(SYNC_LEN);
							skip_d           = '0;
						end
						TGT_FLASH, TGT_COUNT: begin
							push_item.target = cmd_target;
							push_item.done   = stream.stream_end;
							phase_d          = stream.stream_end ? PH_SCAN : PH_RUN;
							target_d         = stream.stream_end ? TGT_NONE : cmd_target;
							count_d          = '0;
							skip_d           = (!stream.stream_end && cmd_target == TGT_FLASH)
								? SKIP_W'(FLASH_SKIP) : '0;
						end
						default: begin
							phase_d = PH_SCAN;
						end
					endcase
				end
				PH_RUN: begin
					if (target_q == TGT_FLASH && skip_q != '0) begin
						// Flash preamble bytes are dropped unless they close the stream.
						skip_d = skip_q - 1'b1;
						if (stream.stream_end) begin
							push             = 1'b1;
							push_item.target = TGT_FLASH;
							push_item.data   = '0;
							push_item.done   = 1'b1;
							push_count       = count_q;
							phase_d          = PH_SCAN;
							target_d         = TGT_NONE;
							count_d          = '0;
							skip_d           = '0;
						end
					end else begin
						push             = 1'b1;
						push_item.target = target_q;
						push_count       = count_inc;
						push_item.done   = stream.stream_end
							|| (target_q != TGT_COUNT && image_hit);
						count_d          = count_inc;
						if (push_item.done) begin
							phase_d  = PH_SCAN;
							target_d = TGT_NONE;
							count_d  = '0;
							skip_d   = '0;
						end
					end
				end
				default: begin
					// Header scan; a mismatching byte is checked again as a first byte.
					push    = 1'b1;
					phase_d = PH_SCAN;
					if (stream.data_byte == HEADER_BYTES[match_pos]) begin
						match_d = match_pos + 1'b1;
					end else begin
						match_d = (stream.data_byte == HEADER_BYTES[0]) ? MATCH_W'(1) : '0;
					end
					if (match_d == MATCH_W'(HDR_LEN)) begin
						match_d = '0;
						phase_d = PH_CMD;
					end
				end
			endcase
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SCAN;
			match_q  <= '0;
			target_q <= TGT_NONE;
			count_q  <= '0;
			skip_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			match_q  <= match_d;
			target_q <= target_d;
			count_q  <= count_d;
			skip_q   <= skip_d;
		end
	end

endmodule

/* rtl/core/csd_queue.sv */
// ----------------------------------------------------------------------------
// Command stream deframer queue
// Short first-in first-out buffer of classified items between front and back.
// ----------------------------------------------------------------------------
module csd_queue #(
	parameter int COUNT_WIDTH = csd_pkg::COUNT_WIDTH_DEF,
	parameter int DEPTH       = csd_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  csd_pkg::item_t         push_item,
	input  logic [COUNT_WIDTH-1:0] push_count,
	output logic                   full,
	input  logic                   pop,
	output logic                   empty,
	output csd_pkg::item_t         head_item,
	output logic [COUNT_WIDTH-1:0] head_count
);
	import csd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	item_t                  items_q [DEPTH];
	logic [COUNT_WIDTH-1:0] counts_q [DEPTH];
	logic [PTR_W-1:0]       wr_q;
	logic [PTR_W-1:0]       rd_q;
	logic [PTR_W:0]         fill_q;
	logic                   do_push;
	logic                   do_pop;

	assign full       = fill_q == (PTR_W + 1)'(DEPTH);
	assign empty      = fill_q == '0;
	assign do_push    = push && !full;
	assign do_pop     = pop && !empty;
	assign head_item  = items_q[rd_q];
	assign head_count = counts_q[rd_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			fill_q <= fill_q + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			items_q[wr_q]  <= push_item;
			counts_q[wr_q] <= push_count;
		end
	end

endmodule

/* rtl/core/csd_back.sv */
// ----------------------------------------------------------------------------
// Command stream deframer back
// Takes items from the queue, expands the configure sync burst into four
// results and holds each result in the output register.
// ----------------------------------------------------------------------------
module csd_back #(
	parameter int COUNT_WIDTH = csd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  csd_pkg::item_t         head_item,
	input  logic [COUNT_WIDTH-1:0] head_count,
	output logic                   pop,
	csd_out_if.source              result
);
	import csd_pkg::*;

	localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(SYNC_LEN - 1);

	logic                   valid_q;
	logic [BEAT_W-1:0]      beat_q;
	logic                   done_hold_q;
	target_t                target_q;
	logic [7:0]             byte_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   done_q;
	logic                   last_q;

	logic                   load;
	logic                   burst;

	assign load  = !valid_q || result.ready;
	assign burst = beat_q != '0;
	assign pop   = load && !burst && !q_empty;

	assign result.valid      = valid_q;
	assign result.target     = target_q;
	assign result.out_byte   = byte_q;
	assign result.byte_count = count_q;
	assign result.image_done = done_q;
	assign result.last       = last_q;

	// Output valid and the sync burst beat counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else if (load) begin
			if (burst) begin
				valid_q <= 1'b1;
				beat_q  <= (beat_q == LAST_BEAT) ? '0 : beat_q + 1'b1;
			end else if (!q_empty) begin
				valid_q <= 1'b1;
				beat_q  <= head_item.sync ? BEAT_W'(1) : '0;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			if (burst) begin
				target_q <= TGT_CONF;
				byte_q   <= SYNC_BYTES[beat_q];
				count_q  <= COUNT_WIDTH'(beat_q) + 1'b1;
				done_q   <= (beat_q == LAST_BEAT) && done_hold_q;
				last_q   <= beat_q == LAST_BEAT;
			end else if (!q_empty) begin
				if (head_item.sync) begin
					target_q    <= TGT_CONF;
					byte_q      <= SYNC_BYTES[0];
					count_q     <= COUNT_WIDTH'(1);
					done_q      <= 1'b0;
					last_q      <= 1'b0;
					done_hold_q <= head_item.done;
				end else begin
					target_q <= head_item.target;
					byte_q   <= head_item.data;
					count_q  <= head_count;
					done_q   <= head_item.done;
					last_q   <= 1'b1;
				end
			end
		end
	end

endmodule

/* bench/deframer_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command stream deframer monitor
// Watches the byte, result and configuration channels of the deframer. It
// keeps its own copy of the registers and of the scan and stream state, works
// out the results of every accepted byte, and compares each accepted result
// field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module deframer_monitor #(
	parameter int COUNT_WIDTH = csd_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	csd_in_if    stream,
	csd_out_if   result,
	csd_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	import csd_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

	typedef struct packed {
		target_t                tgt;
		logic [7:0]             data;
		logic [COUNT_WIDTH-1:0] count;
		logic                   done;
		logic                   last;
	} routed_t;

	// Results still owed by the block, oldest first.
	routed_t due_results[$];

	// Register copy and deframer state.
	cfg_regs_t              regs;
	phase_t                 phase;
	logic [MATCH_W-1:0]     hdr_pos;
	target_t                run_tgt;
	logic [COUNT_WIDTH-1:0] run_count;
	logic [SKIP_W-1:0]      skip_left;

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	task automatic owe(input target_t t, input logic [7:0] d,
		input logic [COUNT_WIDTH-1:0] c, input logic dn, input logic l);
		routed_t r;
		r = '{tgt: t, data: d, count: c, done: dn, last: l};
		due_results.push_back(r);
	endtask

	task automatic close_stream();
		phase     = PH_SCAN;
		hdr_pos   = '0;
		run_tgt   = TGT_NONE;
		run_count = '0;
		skip_left = '0;
	endtask

	// Works out the results that one accepted byte causes.
	task automatic route_byte(input logic [7:0] b, input logic e);
		logic [COUNT_WIDTH-1:0] cnt;
		logic                   dn;
		target_t                t;
		case (phase)
			PH_RUN: begin
				if (run_tgt == TGT_FLASH && skip_left != 0) begin
					// The first payload bytes of a flash stream are dropped.
					skip_left = skip_left - 1'b1;
					if (e) begin
						owe(TGT_FLASH, 8'h00, run_count, 1'b1, 1'b1);
						close_stream();
					end
				end else begin
					cnt = (run_count < COUNT_TOP) ? run_count + 1'b1 : COUNT_TOP;
					dn  = e || (run_tgt != TGT_COUNT && cnt >= regs.image_bytes);
					owe(run_tgt, b, cnt, dn, 1'b1);
					run_count = cnt;
					if (dn) close_stream();
				end
			end
			PH_CMD: begin
				// The counter code has priority, then the flash code.
				t = TGT_NONE;
				if (b == regs.counter_code) t = TGT_COUNT;
				else if (b == regs.flash_code) t = TGT_FLASH;
				else if (b == regs.configure_code) t = TGT_CONF;
				if (t == TGT_NONE) begin
					owe(TGT_NONE, b, '0, 1'b0, 1'b1);
					close_stream();
				end else begin
					run_tgt   = t;
					phase     = PH_RUN;
					run_count = '0;
					skip_left = '0;
					if (t == TGT_CONF) begin
						// The sync word goes out before any payload.
						dn = e || (SYNC_LEN >= regs.image_bytes);
						for (int k = 0; k < SYNC_LEN; k++) begin
							owe(TGT_CONF, SYNC_BYTES[k], COUNT_WIDTH'(k + 1),
								(k == SYNC_LEN - 1) ? dn : 1'b0, k == SYNC_LEN - 1);
						end
						run_count = COUNT_WIDTH'(SYNC_LEN);
						if (dn) close_stream();
					end else begin
						if (t == TGT_FLASH) skip_left = SKIP_W'(FLASH_SKIP);
						owe(t, b, '0, e, 1'b1);
						if (e) close_stream();
					end
				end
			end
			default: begin
				// Header scan; a byte that breaks a partial match may start a new one.
				phase = PH_SCAN;
				if (hdr_pos > 2) hdr_pos = '0;
				if (b == HEADER_BYTES[hdr_pos]) begin
					hdr_pos = hdr_pos + 1'b1;
				end else begin
					hdr_pos = (b == HEADER_BYTES[0]) ? MATCH_W'(1) : '0;
				end
				if (hdr_pos == HDR_LEN) begin
					hdr_pos = '0;
					phase   = PH_CMD;
				end
				owe(TGT_NONE, b, '0, 1'b0, 1'b1);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		routed_t want;
		if (!arst_n) begin
			regs.configure_code = CONFIGURE_CODE_RST;
			regs.flash_code     = FLASH_CODE_RST;
			regs.counter_code   = COUNTER_CODE_RST;
			regs.image_bytes    = IMAGE_BYTES_RST;
			close_stream();
			due_results.delete();
		end else begin
			// Results are checked first; a byte never yields a result in its own cycle.
			if (result.valid && result.ready) begin
				if (due_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result target %0d byte %02h",
						result.target, result.out_byte));
				end else begin
					want = due_results.pop_front();
					if (result.target !== want.tgt)
						flag_mismatch($sformatf("target got %0d want %0d",
							result.target, want.tgt));
					if (result.out_byte !== want.data)
						flag_mismatch($sformatf("out_byte got %02h want %02h",
							result.out_byte, want.data));
					if (result.byte_count !== want.count)
						flag_mismatch($sformatf("byte_count got %0d want %0d",
							result.byte_count, want.count));
					if (result.image_done !== want.done)
						flag_mismatch($sformatf("image_done got %b want %b",
							result.image_done, want.done));
					if (result.last !== want.last)
						flag_mismatch($sformatf("last got %b want %b",
							result.last, want.last));
				end
			end

			if (stream.valid && stream.ready)
				route_byte(stream.data_byte, stream.stream_end);

			// Register writes must only happen while the block is idle; the user is bound, the block does not enforce it.
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_CONFIGURE_CODE: regs.configure_code = cfg.data[CODE_W-1:0];
					REG_FLASH_CODE:     regs.flash_code     = cfg.data[CODE_W-1:0];
					REG_COUNTER_CODE:   regs.counter_code   = cfg.data[CODE_W-1:0];
					REG_IMAGE_BYTES:    regs.image_bytes    = cfg.data;
					default: ;
				endcase
			end
		end
		pending <= due_results.size();
	end

endmodule

/* bench/tb_command_stream_deframer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command stream deframer testbench
// Drives a short directed byte sequence and then random packets (headers,
// commands, payloads, broken headers and noise) through several register
// settings, with random gaps and stalls on both channels. The monitor beside
// the block predicts and checks every result.
// ----------------------------------------------------------------------------
module tb_command_stream_deframer;
	import csd_pkg::*;

	localparam int CNT_W    = COUNT_WIDTH_DEF;
	localparam int IDLE_GAP = 12;

	// Directed bytes: bit 8 is stream_end, bits 7:0 the data byte.
	localparam logic [8:0] DIRECTED [26] = '{
		9'h100, 9'h0FF,                                 // scan extremes, end ignored
		9'h07E, 9'h0AA, 9'h07E, 9'h0AA, 9'h199,         // header broken and rechecked
		9'h002, 9'h0FF, 9'h100,                         // counter stream closed by end
		9'h07E, 9'h07E, 9'h0AA, 9'h099, 9'h05A,         // recheck at second byte, unknown
		9'h07E, 9'h0AA, 9'h099, 9'h001,                 // flash command
		9'h011, 9'h022, 9'h133,                         // end during the flash skip
		9'h07E, 9'h0AA, 9'h099, 9'h17E                  // configure closed on the sync word
	};

	logic clk;
	logic arst_n;
	bit   steady;
	int   fail_count;
	int   pending;
	int   bytes_sent;

	// Current register settings as the stimulus sees them.
	logic [7:0]  code_conf;
	logic [7:0]  code_flash;
	logic [7:0]  code_count;
	logic [23:0] image_len;

	csd_in_if                          in_ch ();
	csd_out_if #(.COUNT_WIDTH(CNT_W))  out_ch ();
	csd_cfg_if                         cfg_ch ();

	command_stream_deframer #(
		.COUNT_WIDTH(CNT_W)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.stream(in_ch),
		.result(out_ch),
		.cfg   (cfg_ch)
	);

	deframer_monitor #(
		.COUNT_WIDTH(CNT_W)
	) u_monitor (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (in_ch),
		.result    (out_ch),
		.cfg       (cfg_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side stalls at random unless a steady stretch is running.
	always @(negedge clk) begin
		out_ch.ready <= steady || ($urandom_range(99) >= 17);
	end

	// Sends one byte, with an optional random gap before it.
	task automatic send_byte(input logic [7:0] b, input logic e);
		while (!steady && $urandom_range(99) < 17) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.data_byte  <= b;
		in_ch.stream_end <= e;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Holds the sender until every result has arrived and the block has settled.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (IDLE_GAP) @(negedge clk);
	endtask

	// Writes all four registers back to back.
	task automatic set_regs(input logic [7:0] c, input logic [7:0] f,
		input logic [7:0] n, input logic [23:0] img);
		cfg_reg_t    idx [4];
		logic [23:0] vals [4];
		idx  = '{REG_CONFIGURE_CODE, REG_FLASH_CODE, REG_COUNTER_CODE, REG_IMAGE_BYTES};
		vals = '{{16'h0, c}, {16'h0, f}, {16'h0, n}, img};
		for (int i = 0; i < 4; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data  <= vals[i];
			do @(posedge clk); while (!cfg_ch.ready);
			@(negedge clk);
		end
		cfg_ch.valid <= 1'b0;
		code_conf  = c;
		code_flash = f;
		code_count = n;
		image_len  = img;
	endtask

	// One random packet: mostly well-formed commands, some noise and broken headers.
	task automatic send_packet();
		int         kind;
		int         pick;
		int         len;
		logic [7:0] cmd;
		logic       e;
		kind = $urandom_range(99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'($urandom_range(1)));
		end else if (kind < 20) begin
			send_byte(HEADER_BYTES[0], 1'b0);
			send_byte($urandom_range(1) ? HEADER_BYTES[0] : HEADER_BYTES[1], 1'b0);
			send_byte(8'($urandom), 1'b0);
		end else begin
			// The command byte may follow a packet that ended on the header.
			send_byte(HEADER_BYTES[0], 1'b0);
			send_byte(HEADER_BYTES[1], 1'b0);
			send_byte(HEADER_BYTES[2], $urandom_range(9) == 0);
			pick = $urandom_range(3);
			case (pick)
				0:       cmd = code_conf;
				1:       cmd = code_flash;
				2:       cmd = code_count;
				default: cmd = 8'($urandom);
			endcase
			e = ($urandom_range(9) == 0);
			send_byte(cmd, e);
			if (!e) begin
				len = (image_len < 24) ? $urandom_range(0, image_len + 8)
				                       : $urandom_range(0, 10);
				if (pick == 1) len += FLASH_SKIP;
				for (int i = 0; i < len; i++) begin
					if (i == len - 1) e = ($urandom_range(9) < 7);
					else e = ($urandom_range(99) < 3);
					send_byte(8'($urandom), e);
				end
			end
		end
	endtask

	task automatic run_random(input int quota);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < quota) send_packet();
	endtask

	initial begin
		in_ch.valid      = 1'b0;
		in_ch.data_byte  = 8'h00;
		in_ch.stream_end = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = REG_CONFIGURE_CODE;
		cfg_ch.data      = '0;
		steady           = 1'b0;
		bytes_sent       = 0;
		code_conf        = CONFIGURE_CODE_RST;
		code_flash       = FLASH_CODE_RST;
		code_count       = COUNTER_CODE_RST;
		image_len        = IMAGE_BYTES_RST;
		arst_n           = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed sequence with the reset settings.
		foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		run_random(25);

		// Random codes and a small image; the sender drains once mid-phase.
		wait_idle();
		set_regs(8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom_range(5, 20)));
		run_random(25);
		wait_idle();
		run_random(25);

		// Overlapping codes and small image sizes, without gaps or stalls.
		wait_idle();
		steady = 1'b1;
		set_regs(8'h5A, 8'h5A, 8'h5A, 24'd1);
		run_random(25);
		wait_idle();
		set_regs(8'h33, 8'h33, 8'h44, 24'd4);
		run_random(25);
		steady = 1'b0;

		// Image size zero cuts configure and flash streams short, not counter ones.
		wait_idle();
		set_regs(8'h00, 8'hFF, 8'h80, 24'd0);
		run_random(25);

		// Largest image; streams end only on stream_end.
		wait_idle();
		set_regs(8'hFF, 8'h00, 8'h7E, 24'hFFFFFF);
		run_random(45);

		wait_idle();
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/csd_pkg.sv
rtl/core/csd_if.sv
rtl/core/csd_front.sv
rtl/core/csd_queue.sv
rtl/core/csd_back.sv
rtl/core/command_stream_deframer.sv
bench/deframer_monitor.sv
bench/tb_command_stream_deframer.sv
